### rtl/core/x86s_pkg.sv
// shared types and constants for the x86 subset execute unit
// no dependencies
`default_nettype none
package x86s_pkg;
  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] CMD_INVALID = 3'd0;
  localparam logic [2:0] CMD_MOV = 3'd1;
  localparam logic [2:0] CMD_ADD = 3'd2;
  localparam logic [2:0] CMD_SUB = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;
  localparam logic [2:0] CMD_JNZ = 3'd5;

  localparam logic [1:0] KIND_REG = 2'd1;
  localparam logic [1:0] KIND_MEM = 2'd2;
  localparam logic [1:0] KIND_IMM = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_MOV,
    OP_ALU,
    OP_JNZ
  } op_class_t;

  // decoded request carried from front to back
  typedef struct packed {
    logic       valid_op;
    op_class_t  op;
    logic       is_sub;
    logic       write_back;
    logic       wide;
    logic [1:0] dst_kind;
    logic [4:0] dst_reg;
    logic [4:0] dst_index;
    logic [15:0] dst_value;
    logic [1:0] src_kind;
    logic [4:0] src_reg;
    logic [4:0] src_index;
    logic [15:0] src_value;
    logic [2:0] instr_size;
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_RD_S0,
    ST_RD_S1,
    ST_RD_D0,
    ST_RD_D1,
    ST_EXEC,
    ST_WR0,
    ST_WR1,
    ST_OUT
  } ex_state_t;
endpackage
`default_nettype wire

### rtl/core/x86s_front.sv
// front end: accepts instructions, classifies them, and queues them
// depends on x86s_pkg
`default_nettype none
module x86s_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [2:0]       in_cmd,
  input  wire logic             in_wide,
  input  wire logic [1:0]       in_dst_kind,
  input  wire logic [4:0]       in_dst_reg,
  input  wire logic [4:0]       in_dst_index,
  input  wire logic [15:0]      in_dst_value,
  input  wire logic [1:0]       in_src_kind,
  input  wire logic [4:0]       in_src_reg,
  input  wire logic [4:0]       in_src_index,
  input  wire logic [15:0]      in_src_value,
  input  wire logic [2:0]       in_instr_size,
  output logic                  q_valid,
  output x86s_pkg::req_t        q_req,
  input  wire logic             q_take
);
  localparam int unsigned DW = $clog2(x86s_pkg::QUEUE_DEPTH);
  x86s_pkg::req_t slot_r [x86s_pkg::QUEUE_DEPTH];
  logic [DW-1:0] wp_r, rp_r;
  logic [DW:0] cnt_r, cnt_nxt;
  x86s_pkg::req_t dec;
  logic push, pop;

  always_comb begin
    dec = '0;
    dec.valid_op = (in_cmd != x86s_pkg::CMD_INVALID);
    dec.wide = in_wide;
    dec.dst_kind = in_dst_kind;
    dec.dst_reg = in_dst_reg;
    dec.dst_index = in_dst_index;
    dec.dst_value = in_dst_value;
    dec.src_kind = in_src_kind;
    dec.src_reg = in_src_reg;
    dec.src_index = in_src_index;
    dec.src_value = in_src_value;
    dec.instr_size = in_instr_size;
    case (in_cmd)
      x86s_pkg::CMD_MOV: begin
        dec.op = x86s_pkg::OP_MOV;
        dec.write_back = 1'b1;
      end
      x86s_pkg::CMD_ADD: begin
        dec.op = x86s_pkg::OP_ALU;
        dec.write_back = 1'b1;
      end
      x86s_pkg::CMD_SUB: begin
        dec.op = x86s_pkg::OP_ALU;
        dec.is_sub = 1'b1;
        dec.write_back = 1'b1;
      end
      x86s_pkg::CMD_CMP: begin
        dec.op = x86s_pkg::OP_ALU;
        dec.is_sub = 1'b1;
      end
      x86s_pkg::CMD_JNZ: dec.op = x86s_pkg::OP_JNZ;
      default: dec.op = x86s_pkg::OP_NOP;
    endcase
    // write-back only to register or memory
    if (in_dst_kind != x86s_pkg::KIND_REG && in_dst_kind != x86s_pkg::KIND_MEM)
      dec.write_back = 1'b0;
  end

  assign in_stall = (cnt_r == (DW+1)'(x86s_pkg::QUEUE_DEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != '0);
  assign pop = q_take && q_valid;
  assign q_req = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= dec;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (DW+1)'(x86s_pkg::QUEUE_DEPTH)) else $error("queue overfill");
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("push lost");
  a_pop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1)) else $error("pop lost");
endmodule
`default_nettype wire

### rtl/core/x86s_back.sv
// back end: operand fetch, alu, write-back and result register
// depends on x86s_pkg
`default_nettype none
module x86s_back #(
  parameter int unsigned MEM_BYTES = x86s_pkg::MEM_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  x86s_pkg::req_t        q_req,
  output logic                  q_take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_accepted,
  output logic [15:0]           out_result_value,
  output logic                  out_zero_flag,
  output logic                  out_sign_flag,
  output logic                  out_carry_flag,
  output logic                  out_overflow_flag,
  output logic [15:0]           out_instr_pointer
);
  localparam int unsigned AW = $clog2(MEM_BYTES);

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] rd_q;
  logic [AW-1:0] mem_addr;
  logic mem_we;
  logic [7:0] mem_wd;

  logic [15:0] rf_r [8];
  logic zf_r, sf_r, cf_r, of_r;
  logic [15:0] ip_r;

  x86s_pkg::ex_state_t st_r, st_nxt;
  x86s_pkg::req_t cur_r;
  logic [AW:0] clr_r;
  logic [15:0] sa_r, da_r;
  logic [15:0] sa_c, da_c;
  logic [15:0] sv_r, dv_r, res_r;
  logic ov_r;
  logic o_acc_r;
  logic [15:0] o_res_r;
  logic o_zf_r, o_sf_r, o_cf_r, o_of_r;
  logic [15:0] o_ip_r;

  function automatic logic [15:0] rd_reg(input logic [15:0] rf [8], input logic [4:0] c,
                                         input logic w);
    logic [15:0] v;
    v = '0;
    if (w) begin
      if (!c[4] && !c[3]) v = rf[c[2:0]];
    end else if (!c[4] && c[3]) begin
      if (!c[2]) v = {8'h00, rf[{1'b0, c[1:0]}][7:0]};
      else v = {8'h00, rf[{1'b0, c[1:0]}][15:8]};
    end
    return v;
  endfunction

  function automatic logic [15:0] addr_reg(input logic [15:0] rf [8], input logic [4:0] c);
    return (c[4:3] == 2'b00) ? rf[c[2:0]] : 16'h0000;
  endfunction

  // register file write, byte halves merged
  task automatic rf_wr(input logic [4:0] c, input logic w, input logic [15:0] v);
    if (w) begin
      if (c[4:3] == 2'b00) rf_r[c[2:0]] <= v;
    end else if (c[4:3] == 2'b01) begin
      if (!c[2]) rf_r[{1'b0, c[1:0]}][7:0] <= v[7:0];
      else rf_r[{1'b0, c[1:0]}][15:8] <= v[7:0];
    end
  endtask

  logic src_mem, dst_mem, dst_needed;
  assign src_mem = (cur_r.src_kind == x86s_pkg::KIND_MEM);
  assign dst_mem = (cur_r.dst_kind == x86s_pkg::KIND_MEM);
  assign dst_needed = (cur_r.op == x86s_pkg::OP_ALU);

  // effective addresses from the current register file
  assign sa_c = cur_r.src_value + addr_reg(rf_r, cur_r.src_reg) +
                addr_reg(rf_r, cur_r.src_index);
  assign da_c = cur_r.dst_value + addr_reg(rf_r, cur_r.dst_reg) +
                addr_reg(rf_r, cur_r.dst_index);

  // alu
  logic [15:0] mask, top;
  logic [16:0] sum;
  logic [15:0] alu_res;
  logic alu_cf, alu_of, ds, ss, rs;
  always_comb begin
    mask = cur_r.wide ? 16'hFFFF : 16'h00FF;
    top = cur_r.wide ? 16'h8000 : 16'h0080;
    ds = (dv_r & top) != '0;
    ss = (sv_r & top) != '0;
    if (cur_r.is_sub) sum = {1'b0, dv_r} - {1'b0, sv_r};
    else sum = {1'b0, dv_r} + {1'b0, sv_r};
    alu_res = sum[15:0] & mask;
    rs = (alu_res & top) != '0;
    if (cur_r.is_sub) begin
      alu_cf = dv_r < sv_r;
      alu_of = (ds != ss) && (rs != ds);
    end else begin
      alu_cf = cur_r.wide ? sum[16] : sum[8];
      alu_of = (ds == ss) && (rs != ds);
    end
  end

  logic [15:0] off;
  assign off = {{8{cur_r.dst_value[7]}}, cur_r.dst_value[7:0]};

  // values produced by the execute step
  logic [15:0] ex_res, ex_ip;
  logic ex_zf, ex_sf, ex_cf, ex_of;
  logic ex_fire, ex_rf_we;
  always_comb begin
    ex_res = '0;
    ex_zf = zf_r;
    ex_sf = sf_r;
    ex_cf = cf_r;
    ex_of = of_r;
    ex_ip = ip_r;
    if (cur_r.valid_op) begin
      case (cur_r.op)
        x86s_pkg::OP_MOV: ex_res = sv_r & mask;
        x86s_pkg::OP_ALU: begin
          ex_res = alu_res;
          ex_zf = (alu_res == '0);
          ex_sf = rs;
          ex_cf = alu_cf;
          ex_of = alu_of;
        end
        x86s_pkg::OP_JNZ: if (!zf_r) ex_ip = ip_r + {13'd0, cur_r.instr_size} + off;
        default: ;
      endcase
    end
  end

  assign ex_fire = (st_r == x86s_pkg::ST_EXEC) && !(ov_r && out_stall);
  assign ex_rf_we = cur_r.valid_op && cur_r.write_back &&
                    (cur_r.dst_kind == x86s_pkg::KIND_REG) &&
                    (cur_r.op == x86s_pkg::OP_MOV || cur_r.op == x86s_pkg::OP_ALU);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      x86s_pkg::ST_CLEAR: if (clr_r == (AW+1)'(MEM_BYTES - 1)) st_nxt = x86s_pkg::ST_IDLE;
      x86s_pkg::ST_IDLE: if (q_valid) st_nxt = x86s_pkg::ST_ADDR;
      x86s_pkg::ST_ADDR: begin
        if (!cur_r.valid_op || cur_r.op == x86s_pkg::OP_NOP || cur_r.op == x86s_pkg::OP_JNZ)
          st_nxt = x86s_pkg::ST_EXEC;
        else if (src_mem) st_nxt = x86s_pkg::ST_RD_S0;
        else if (dst_needed && dst_mem) st_nxt = x86s_pkg::ST_RD_D0;
        else st_nxt = x86s_pkg::ST_EXEC;
      end
      x86s_pkg::ST_RD_S0: begin
        if (cur_r.wide) st_nxt = x86s_pkg::ST_RD_S1;
        else if (dst_needed && dst_mem) st_nxt = x86s_pkg::ST_RD_D0;
        else st_nxt = x86s_pkg::ST_EXEC;
      end
      x86s_pkg::ST_RD_S1: begin
        if (dst_needed && dst_mem) st_nxt = x86s_pkg::ST_RD_D0;
        else st_nxt = x86s_pkg::ST_EXEC;
      end
      x86s_pkg::ST_RD_D0: st_nxt = cur_r.wide ? x86s_pkg::ST_RD_D1 : x86s_pkg::ST_EXEC;
      x86s_pkg::ST_RD_D1: st_nxt = x86s_pkg::ST_EXEC;
      x86s_pkg::ST_EXEC: begin
        if (ov_r && out_stall) st_nxt = x86s_pkg::ST_EXEC;
        else if (cur_r.write_back && dst_mem && cur_r.op != x86s_pkg::OP_JNZ &&
                 cur_r.op != x86s_pkg::OP_NOP && cur_r.valid_op)
          st_nxt = x86s_pkg::ST_WR0;
        else st_nxt = x86s_pkg::ST_IDLE;
      end
      x86s_pkg::ST_WR0: st_nxt = cur_r.wide ? x86s_pkg::ST_WR1 : x86s_pkg::ST_IDLE;
      x86s_pkg::ST_WR1: st_nxt = x86s_pkg::ST_IDLE;
      default: st_nxt = x86s_pkg::ST_IDLE;
    endcase
  end

  // memory port control (outputs); each state presents the address of the byte
  // that the following state captures
  always_comb begin
    mem_we = 1'b0;
    mem_wd = '0;
    mem_addr = '0;
    q_take = 1'b0;
    case (st_r)
      x86s_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_r[AW-1:0];
      end
      x86s_pkg::ST_IDLE: q_take = q_valid;
      x86s_pkg::ST_ADDR: mem_addr = src_mem ? sa_c[AW-1:0] : da_c[AW-1:0];
      x86s_pkg::ST_RD_S0: mem_addr = cur_r.wide ? AW'(sa_r + 16'd1) : da_r[AW-1:0];
      x86s_pkg::ST_RD_S1: mem_addr = da_r[AW-1:0];
      x86s_pkg::ST_RD_D0: mem_addr = AW'(da_r + 16'd1);
      x86s_pkg::ST_WR0: begin
        mem_we = 1'b1;
        mem_addr = da_r[AW-1:0];
        mem_wd = res_r[7:0];
      end
      x86s_pkg::ST_WR1: begin
        mem_we = 1'b1;
        mem_addr = AW'(da_r + 16'd1);
        mem_wd = res_r[15:8];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    case (st_r)
      x86s_pkg::ST_IDLE: if (q_valid) cur_r <= q_req;
      x86s_pkg::ST_ADDR: begin
        sa_r <= sa_c;
        da_r <= da_c;
      end
      default: ;
    endcase
  end

  // operand capture; memory bytes arrive one state after their address
  always_ff @(posedge clk) begin
    case (st_r)
      x86s_pkg::ST_ADDR: begin
        case (cur_r.src_kind)
          x86s_pkg::KIND_REG: sv_r <= rd_reg(rf_r, cur_r.src_reg, cur_r.wide);
          x86s_pkg::KIND_IMM: sv_r <= cur_r.src_value & (cur_r.wide ? 16'hFFFF : 16'h00FF);
          default: sv_r <= '0;
        endcase
        case (cur_r.dst_kind)
          x86s_pkg::KIND_REG: dv_r <= rd_reg(rf_r, cur_r.dst_reg, cur_r.wide);
          x86s_pkg::KIND_IMM: dv_r <= cur_r.dst_value & (cur_r.wide ? 16'hFFFF : 16'h00FF);
          default: dv_r <= '0;
        endcase
      end
      x86s_pkg::ST_RD_S0: sv_r <= {8'h00, rd_q};
      x86s_pkg::ST_RD_S1: sv_r[15:8] <= rd_q;
      x86s_pkg::ST_RD_D0: dv_r <= {8'h00, rd_q};
      x86s_pkg::ST_RD_D1: dv_r[15:8] <= rd_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= x86s_pkg::ST_CLEAR;
      clr_r <= '0;
      zf_r <= 1'b0;
      sf_r <= 1'b0;
      cf_r <= 1'b0;
      of_r <= 1'b0;
      ip_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < 8; i++) rf_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == x86s_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (ex_fire) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (ex_fire) begin
        zf_r <= ex_zf;
        sf_r <= ex_sf;
        cf_r <= ex_cf;
        of_r <= ex_of;
        ip_r <= ex_ip;
        if (ex_rf_we) rf_wr(cur_r.dst_reg, cur_r.wide, ex_res);
      end
    end
  end

  // result register, held while the result waits
  always_ff @(posedge clk) begin
    if (ex_fire) begin
      o_acc_r <= cur_r.valid_op;
      o_res_r <= ex_res;
      res_r <= ex_res;
      o_zf_r <= ex_zf;
      o_sf_r <= ex_sf;
      o_cf_r <= ex_cf;
      o_of_r <= ex_of;
      o_ip_r <= ex_ip;
    end
  end

  assign out_valid = ov_r;
  assign out_accepted = o_acc_r;
  assign out_result_value = o_res_r;
  assign out_zero_flag = o_zf_r;
  assign out_sign_flag = o_sf_r;
  assign out_carry_flag = o_cf_r;
  assign out_overflow_flag = o_of_r;
  assign out_instr_pointer = o_ip_r;

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> (st_r == x86s_pkg::ST_IDLE)) else $error("take while busy");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == x86s_pkg::ST_CLEAR) |-> !q_take && !out_valid) else $error("busy in clear");
  a_ip_only_jnz: assert property (@(posedge clk) disable iff (!rst_n)
    (ip_r != $past(ip_r)) |-> ($past(st_r) == x86s_pkg::ST_EXEC)) else $error("ip moved");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(ov_r) && $past(out_stall)) |-> ov_r) else $error("result dropped");
endmodule
`default_nettype wire

### rtl/core/x86_16_subset_execute_unit.sv
// execute unit for a 16-bit x86 subset: front queue plus sequenced back end
// depends on x86s_pkg, x86s_front, x86s_back
// sequence: a request is taken when the back end is idle, its addresses are formed,
//   each memory operand byte is read in its own state, and it executes into the result
//   register, waiting while an earlier result is stalled; a memory destination is then
//   written byte by byte to the single-ported byte memory, one instruction at a time
// reset: synchronous rst_n; afterwards a clearing pass zeroes the byte memory, and
//   instructions are queued but not executed until it ends
`default_nettype none
module x86_16_subset_execute_unit #(
  parameter int unsigned MEM_BYTES = x86s_pkg::MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_cmd,
  input  wire logic        in_wide,
  input  wire logic [1:0]  in_dst_kind,
  input  wire logic [4:0]  in_dst_reg,
  input  wire logic [4:0]  in_dst_index,
  input  wire logic [15:0] in_dst_value,
  input  wire logic [1:0]  in_src_kind,
  input  wire logic [4:0]  in_src_reg,
  input  wire logic [4:0]  in_src_index,
  input  wire logic [15:0] in_src_value,
  input  wire logic [2:0]  in_instr_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_accepted,
  output logic [15:0]      out_result_value,
  output logic             out_zero_flag,
  output logic             out_sign_flag,
  output logic             out_carry_flag,
  output logic             out_overflow_flag,
  output logic [15:0]      out_instr_pointer
);
  // decoded request queue between front and back
  logic q_valid, q_take;
  x86s_pkg::req_t q_req;

  x86s_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_wide(in_wide), .in_dst_kind(in_dst_kind),
    .in_dst_reg(in_dst_reg), .in_dst_index(in_dst_index), .in_dst_value(in_dst_value),
    .in_src_kind(in_src_kind), .in_src_reg(in_src_reg), .in_src_index(in_src_index),
    .in_src_value(in_src_value), .in_instr_size(in_instr_size),
    .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
  );

  // back end owns register file, flags, ip and the byte memory
  x86s_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req), .q_take(q_take),
    .out_valid(out_valid), .out_stall(out_stall), .out_accepted(out_accepted),
    .out_result_value(out_result_value), .out_zero_flag(out_zero_flag),
    .out_sign_flag(out_sign_flag), .out_carry_flag(out_carry_flag),
    .out_overflow_flag(out_overflow_flag), .out_instr_pointer(out_instr_pointer)
  );
endmodule
`default_nettype wire
